/* hw/rtl/frame_perceptual_scorer_core_macros.svh */
// assertion helpers for the frame scorer checker
`ifndef FRAME_PERCEPTUAL_SCORER_CORE_MACROS_SVH
`define FRAME_PERCEPTUAL_SCORER_CORE_MACROS_SVH

// same-cycle implication
`define FPS_ASSERT_NOW(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPS_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fps_pkg.sv */
`default_nettype none
package fps_pkg;

	localparam int PIX_W      = 8;
	localparam int SCORE_W    = 17;
	localparam int FW_W       = 9;
	localparam int FH_W       = 8;
	localparam int THR_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int MAG_W      = 32;
	localparam int SQ_W       = 21;
	localparam int ROOT_W     = 16;
	localparam int DIV_DW     = 49;
	localparam int ONE_Q16    = 65536;

	localparam logic [FW_W-1:0]  FW_RST  = 9'd320;
	localparam logic [FH_W-1:0]  FH_RST  = 8'd240;
	localparam logic [THR_W-1:0] THR_RST = 8'd30;

	localparam logic [3:0] TAP_CNT = 4'd9;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH      = 2'd0,
		CFG_FRAME_HEIGHT     = 2'd1,
		CFG_MOTION_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PIX,
		ST_SOB_RD,
		ST_SOB_SQ,
		ST_SOB_ST,
		ST_SOB_RT,
		ST_DIV_N,
		ST_DIV_K,
		ST_DIV_GO,
		ST_DIV_RUN,
		ST_SUM,
		ST_SCALE,
		ST_DONE
	} fps_state_t;

	function automatic logic [1:0] mod3_inc(input logic [1:0] v);
		logic [1:0] r;
		case (v)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] mod3_dec(input logic [1:0] v);
		logic [1:0] r;
		case (v)
			2'd1: r = 2'd0;
			2'd2: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	// tap k of the 3x3 window: row k/3, column k%3
	function automatic logic [1:0] tap_row(input logic [3:0] k);
		logic [1:0] r;
		case (k)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] tap_col(input logic [3:0] k);
		logic [1:0] r;
		case (k)
			4'd0, 4'd3, 4'd6: r = 2'd0;
			4'd1, 4'd4, 4'd7: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic signed [2:0] tap_wx(input logic [3:0] k);
		logic signed [2:0] r;
		case (k)
			4'd0, 4'd6: r = -3'sd1;
			4'd2, 4'd8: r = 3'sd1;
			4'd3:       r = -3'sd2;
			4'd5:       r = 3'sd2;
			default:    r = 3'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [2:0] tap_wy(input logic [3:0] k);
		logic signed [2:0] r;
		case (k)
			4'd0, 4'd2: r = -3'sd1;
			4'd6, 4'd8: r = 3'sd1;
			4'd1:       r = -3'sd2;
			4'd7:       r = 3'sd2;
			default:    r = 3'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/fps_if.sv */
`default_nettype none
interface fps_pix_if;
	import fps_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             frame_start;
	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface fps_res_if;
	import fps_pkg::*;
	logic               valid;
	logic               ready;
	logic [SCORE_W-1:0] score;
	logic [SCORE_W-1:0] motion_score;
	logic [SCORE_W-1:0] edge_score;
	logic [SCORE_W-1:0] stability_score;
	modport source (output valid, output score, output motion_score, output edge_score,
		output stability_score, input ready);
	modport sink (input valid, input score, input motion_score, input edge_score,
		input stability_score, output ready);
endinterface

interface fps_cfg_if;
	import fps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/frame_perceptual_scorer_core.sv */
// frame perceptual scorer
// pixels: gray pixels in raster order, frame_start marks the first pixel of
//   a frame and resets the position counters
// cfg: register writes (0 frame width, 1 frame height, 2 motion threshold),
//   always ready; sizes take effect at the next frame start
// results: one transaction per completed frame with score, motion_score,
//   edge_score and stability_score in Q1.16
// a pixel is taken, its previous-frame byte read and then written back;
//   each 3x3 Sobel window adds 9 line buffer reads, the squaring states and
//   the bit-serial square root; interior pixels carry one window, border
//   pixels up to 4 windows; pixels.ready stays low until they are done, and
//   the single read port of the line buffer and the root unit bound the rate
// the last pixel of a frame adds 3 divisions (motion, edge, stability) and
//   the setup and weighting states before the result is registered
// after reset the previous-frame store is cleared one entry a cycle, all
//   MAX_WIDTH * MAX_HEIGHT entries, while pixels.ready stays low
// a stalled result holds in the output register while pixels of the next
//   frame are taken; only the following result waits for it to drain
`default_nettype none
module frame_perceptual_scorer_core #(
	parameter int MAX_WIDTH  = 320,
	parameter int MAX_HEIGHT = 240
) (
	input  logic      clk,
	input  logic      arst_n,
	fps_cfg_if.sink   cfg,
	fps_pix_if.sink   pixels,
	fps_res_if.source results
);
	import fps_pkg::*;

	localparam int UWW    = $clog2(MAX_WIDTH + 1);
	localparam int UHW    = $clog2(MAX_HEIGHT + 1);
	localparam int PDEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int PA     = $clog2(PDEPTH);
	localparam int LDEPTH = 3 * MAX_WIDTH;
	localparam int LA     = $clog2(LDEPTH);
	localparam int NW     = $clog2(PDEPTH + 1);
	localparam int DFW    = $clog2(255 * PDEPTH + 1);
	localparam longint unsigned VMAX = 64'd800 * 64'(PDEPTH);
	localparam int VW     = $clog2(VMAX + 64'd1);
	localparam int RST_UW = (320 > MAX_WIDTH) ? MAX_WIDTH : 320;
	localparam int RST_UH = (240 > MAX_HEIGHT) ? MAX_HEIGHT : 240;
	// x / 10 as (x * RECIP10) >> 23, exact for x below 2^22
	localparam int WSW = 20;
	localparam logic [WSW-1:0] RECIP10 = 20'd838861;

	fps_state_t state_q, state_d;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [THR_W-1:0] thr_q;

	logic [UWW-1:0] col_q, used_w_q, last_w_q, col_s1, cw;
	logic [UHW-1:0] row_q, used_h_q, last_h_q, row_s1, chh;
	logic [1:0]     rm_q, rm_s1;
	logic [PA-1:0]  idx_q, idx_s1, clr_q;
	logic [PIX_W-1:0] pix_s1;
	logic           eof_s1, pzero_s1;
	logic [3:0]     jobs_q;

	logic [NW-1:0]    changed_q;
	logic [DFW-1:0]   diff_q;
	logic [MAG_W-1:0] mag_q;

	// accept-side comb
	logic           acc, fs, first, wrap_c, wrap_r;
	logic [UWW-1:0] e_col, uw;
	logic [UHW-1:0] e_row, uh;
	logic [1:0]     e_rm;
	logic [PA-1:0]  e_idx;
	logic [UWW:0]   col_nx;
	logic [UHW:0]   row_nx;
	logic [3:0]     jobs_new;
	logic [LA-1:0]  ls_waddr;

	// memories
	logic              prev_we;
	logic [PA-1:0]     prev_waddr;
	logic [PIX_W-1:0]  prev_wdata, prev_rdata, ls_rdata;
	logic              ls_re;
	logic [LA-1:0]     ls_raddr;

	// pixel update
	logic [PIX_W-1:0] prev_px, dpx;

	// sobel window
	logic           up, left;
	logic [UHW-1:0] cr;
	logic [UWW-1:0] ccol, lcol, rcol, csel;
	logic [1:0]     crm, top_m, bot_m, rsel;
	logic [3:0]     tap_q, rdt_q;
	logic           rdv_q;
	logic signed [11:0] gx_q, gy_q, tx, ty;
	logic signed [23:0] sqx, sqy;
	logic [SQ_W-1:0]    sumsq_q;
	logic               sq_go, sq_done;
	logic [ROOT_W-1:0]  root;
	logic [MAG_W:0]     mag_sum;

	// end of frame
	logic [NW-1:0]      n_q;
	logic [VW-1:0]      n255_q, n800_q, div_den;
	logic [1:0]         dsel_q;
	logic               div_go, div_done;
	logic [DIV_DW-1:0]  div_num, div_q;
	logic [SCORE_W-1:0] m_q, e_q, s_q, t_q, q_clamp;
	logic [WSW-1:0]     wsum_q;
	logic [2*WSW-1:0]   wprod;

	logic               res_valid_q;
	logic [SCORE_W-1:0] res_score_q, res_motion_q, res_edge_q, res_stab_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FW_RST;
			fh_q  <= FH_RST;
			thr_q <= THR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FRAME_WIDTH:      fw_q  <= cfg.data;
				CFG_FRAME_HEIGHT:     fh_q  <= cfg.data[FH_W-1:0];
				CFG_MOTION_THRESHOLD: thr_q <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(fw_q) < 3) begin
			cw = UWW'(3);
		end else if (int'(fw_q) > MAX_WIDTH) begin
			cw = UWW'(MAX_WIDTH);
		end else begin
			cw = UWW'(fw_q);
		end
		if (int'(fh_q) < 3) begin
			chh = UHW'(3);
		end else if (int'(fh_q) > MAX_HEIGHT) begin
			chh = UHW'(MAX_HEIGHT);
		end else begin
			chh = UHW'(fh_q);
		end
	end

	// position of the incoming pixel
	assign pixels.ready = (state_q == ST_IDLE);
	assign acc    = pixels.valid && pixels.ready;
	assign fs     = pixels.frame_start;
	assign e_col  = fs ? '0 : col_q;
	assign e_row  = fs ? '0 : row_q;
	assign e_rm   = fs ? 2'd0 : rm_q;
	assign e_idx  = fs ? '0 : idx_q;
	assign first  = (e_col == '0) && (e_row == '0);
	assign uw     = first ? cw : used_w_q;
	assign uh     = first ? chh : used_h_q;
	assign col_nx = {1'b0, e_col} + 1'b1;
	assign row_nx = {1'b0, e_row} + 1'b1;
	assign wrap_c = col_nx >= {1'b0, uw};
	assign wrap_r = wrap_c && (row_nx >= {1'b0, uh});
	assign ls_waddr = LA'(e_rm) * LA'(MAX_WIDTH) + LA'(e_col);

	always_comb begin
		logic lc, rg, cg, rl;
		lc = (e_col == uw - 1'b1);
		rg = (e_row != '0);
		cg = (e_col != '0);
		rl = (e_row == uh - 1'b1);
		jobs_new = {rl && cg && lc, rl && cg, rg && cg && lc, rg && cg};
	end

	// window of the lowest pending job
	always_comb begin
		if (jobs_q[0]) begin
			up = 1'b1; left = 1'b1;
		end else if (jobs_q[1]) begin
			up = 1'b1; left = 1'b0;
		end else if (jobs_q[2]) begin
			up = 1'b0; left = 1'b1;
		end else begin
			up = 1'b0; left = 1'b0;
		end
		cr    = up ? row_s1 - 1'b1 : row_s1;
		crm   = up ? mod3_dec(rm_s1) : rm_s1;
		ccol  = left ? col_s1 - 1'b1 : col_s1;
		top_m = (cr == '0) ? mod3_inc(crm) : mod3_dec(crm);
		bot_m = (cr == used_h_q - 1'b1) ? mod3_dec(crm) : mod3_inc(crm);
		lcol  = (ccol == '0) ? UWW'(1) : ccol - 1'b1;
		rcol  = (ccol == used_w_q - 1'b1) ? ccol - 1'b1 : ccol + 1'b1;
		case (tap_row(tap_q))
			2'd0:    rsel = top_m;
			2'd1:    rsel = crm;
			default: rsel = bot_m;
		endcase
		case (tap_col(tap_q))
			2'd0:    csel = lcol;
			2'd1:    csel = ccol;
			default: csel = rcol;
		endcase
		ls_raddr = LA'(rsel) * LA'(MAX_WIDTH) + LA'(csel);
	end

	assign prev_px = pzero_s1 ? '0 : prev_rdata;
	assign dpx     = (pix_s1 > prev_px) ? pix_s1 - prev_px : prev_px - pix_s1;
	assign tx      = tap_wx(rdt_q) * $signed({1'b0, ls_rdata});
	assign ty      = tap_wy(rdt_q) * $signed({1'b0, ls_rdata});
	assign sqx     = gx_q * gx_q;
	assign sqy     = gy_q * gy_q;
	assign mag_sum = {1'b0, mag_q} + (MAG_W + 1)'(root);
	assign wprod   = (2*WSW)'(wsum_q) * (2*WSW)'(RECIP10);

	always_comb begin
		case (dsel_q)
			2'd0: begin
				div_num = (DIV_DW'(changed_q) * DIV_DW'(10) << 16) + DIV_DW'(n_q >> 1);
				div_den = VW'(n_q);
			end
			2'd1: begin
				div_num = (DIV_DW'(mag_q) << 16) + DIV_DW'(n800_q >> 1);
				div_den = n800_q;
			end
			default: begin
				div_num = (DIV_DW'(diff_q) << 16) + DIV_DW'(n255_q >> 1);
				div_den = n255_q;
			end
		endcase
		q_clamp = (div_q > DIV_DW'(ONE_Q16)) ? SCORE_W'(ONE_Q16) : SCORE_W'(div_q);
	end

	always_comb begin
		state_d    = state_q;
		prev_we    = 1'b0;
		prev_waddr = idx_s1;
		prev_wdata = pix_s1;
		ls_re      = 1'b0;
		sq_go      = 1'b0;
		div_go     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				prev_we    = 1'b1;
				prev_waddr = clr_q;
				prev_wdata = '0;
				if (clr_q == PA'(PDEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) state_d = ST_PIX;
			end
			ST_PIX: begin
				prev_we = 1'b1;
				if (jobs_q != '0) state_d = ST_SOB_RD;
				else if (eof_s1) state_d = ST_DIV_N;
				else state_d = ST_IDLE;
			end
			ST_SOB_RD: begin
				ls_re = (tap_q != TAP_CNT);
				if (tap_q == TAP_CNT) state_d = ST_SOB_SQ;
			end
			ST_SOB_SQ: state_d = ST_SOB_ST;
			ST_SOB_ST: begin
				sq_go   = 1'b1;
				state_d = ST_SOB_RT;
			end
			ST_SOB_RT: begin
				if (sq_done) begin
					if ((jobs_q & (jobs_q - 1'b1)) != '0) state_d = ST_SOB_RD;
					else if (eof_s1) state_d = ST_DIV_N;
					else state_d = ST_IDLE;
				end
			end
			ST_DIV_N: state_d = ST_DIV_K;
			ST_DIV_K: state_d = ST_DIV_GO;
			ST_DIV_GO: begin
				div_go  = 1'b1;
				state_d = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (div_done) state_d = (dsel_q == 2'd2) ? ST_SUM : ST_DIV_GO;
			end
			ST_SUM: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_DONE;
			ST_DONE: begin
				if (!res_valid_q || results.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			rm_q        <= 2'd0;
			idx_q       <= '0;
			used_w_q    <= UWW'(RST_UW);
			used_h_q    <= UHW'(RST_UH);
			last_w_q    <= UWW'(RST_UW);
			last_h_q    <= UHW'(RST_UH);
			jobs_q      <= '0;
			eof_s1      <= 1'b0;
			tap_q       <= '0;
			rdt_q       <= '0;
			rdv_q       <= 1'b0;
			dsel_q      <= 2'd0;
			changed_q   <= '0;
			diff_q      <= '0;
			mag_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			rdv_q <= ls_re;
			if (state_q == ST_DONE && (!res_valid_q || results.ready)) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end

			if (acc) begin
				col_q  <= wrap_c ? '0 : UWW'(col_nx);
				row_q  <= wrap_c ? (wrap_r ? '0 : UHW'(row_nx)) : e_row;
				rm_q   <= wrap_c ? (wrap_r ? 2'd0 : mod3_inc(e_rm)) : e_rm;
				idx_q  <= wrap_r ? '0 : e_idx + 1'b1;
				jobs_q <= jobs_new;
				eof_s1 <= wrap_r;
				if (first) begin
					used_w_q  <= cw;
					used_h_q  <= chh;
					changed_q <= '0;
					diff_q    <= '0;
					mag_q     <= '0;
				end
			end

			if (state_q == ST_PIX) begin
				changed_q <= changed_q + NW'(dpx > thr_q);
				diff_q    <= diff_q + DFW'(dpx);
			end

			if (ls_re) begin
				tap_q <= tap_q + 1'b1;
				rdt_q <= tap_q;
			end
			if (state_q == ST_SOB_SQ) tap_q <= '0;

			if (state_q == ST_SOB_RT && sq_done) begin
				mag_q  <= mag_sum[MAG_W] ? '1 : mag_sum[MAG_W-1:0];
				jobs_q <= jobs_q & (jobs_q - 1'b1);
			end

			if (state_q == ST_DIV_K) dsel_q <= 2'd0;
			if (state_q == ST_DIV_RUN && div_done) dsel_q <= dsel_q + 1'b1;

			if (state_q == ST_DONE && (!res_valid_q || results.ready)) begin
				last_w_q    <= used_w_q;
				last_h_q    <= used_h_q;
				changed_q   <= '0;
				diff_q      <= '0;
				mag_q       <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1   <= pixels.pixel;
			col_s1   <= e_col;
			row_s1   <= e_row;
			rm_s1    <= e_rm;
			idx_s1   <= e_idx;
			pzero_s1 <= (uw != last_w_q) || (uh != last_h_q);
		end
		if (ls_re && tap_q == '0) begin
			gx_q <= '0;
			gy_q <= '0;
		end else if (rdv_q) begin
			gx_q <= gx_q + tx;
			gy_q <= gy_q + ty;
		end
		if (state_q == ST_SOB_SQ) sumsq_q <= SQ_W'(sqx) + SQ_W'(sqy);
		if (state_q == ST_DIV_N) n_q <= NW'(used_w_q) * NW'(used_h_q);
		if (state_q == ST_DIV_K) begin
			n255_q <= VW'(n_q) * VW'(255);
			n800_q <= VW'(n_q) * VW'(800);
		end
		if (state_q == ST_DIV_RUN && div_done) begin
			case (dsel_q)
				2'd0: m_q <= q_clamp;
				2'd1: e_q <= q_clamp;
				default: s_q <= (div_q > DIV_DW'(ONE_Q16)) ? '0
					: SCORE_W'(ONE_Q16) - SCORE_W'(div_q);
			endcase
		end
		if (state_q == ST_SUM) begin
			wsum_q <= WSW'(m_q) * WSW'(5) + WSW'(e_q) * WSW'(3)
				+ WSW'(s_q) * WSW'(2) + WSW'(5);
		end
		if (state_q == ST_SCALE) begin
			t_q <= (wprod[39:23] > SCORE_W'(ONE_Q16)) ? SCORE_W'(ONE_Q16) : wprod[39:23];
		end
		if (state_q == ST_DONE && (!res_valid_q || results.ready)) begin
			res_score_q  <= t_q;
			res_motion_q <= m_q;
			res_edge_q   <= e_q;
			res_stab_q   <= s_q;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.score           = res_score_q;
	assign results.motion_score    = res_motion_q;
	assign results.edge_score      = res_edge_q;
	assign results.stability_score = res_stab_q;

	fps_ram #(.WIDTH(PIX_W), .DEPTH(PDEPTH)) u_prev (
		.clk     (clk),
		.wr_en   (prev_we),
		.wr_addr (prev_waddr),
		.wr_data (prev_wdata),
		.rd_en   (acc),
		.rd_addr (e_idx),
		.rd_data (prev_rdata)
	);

	fps_ram #(.WIDTH(PIX_W), .DEPTH(LDEPTH)) u_lines (
		.clk     (clk),
		.wr_en   (acc),
		.wr_addr (ls_waddr),
		.wr_data (pixels.pixel),
		.rd_en   (ls_re),
		.rd_addr (ls_raddr),
		.rd_data (ls_rdata)
	);

	fps_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_go),
		.radicand ({3'b000, sumsq_q, 8'h00}),
		.done     (sq_done),
		.root     (root)
	);

	fps_div #(.DW(DIV_DW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);
endmodule
`default_nettype wire

/* hw/rtl/fps_ram.sv */
`default_nettype none
module fps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/fps_sqrt.sv */
`default_nettype none
module fps_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [31:0]               radicand,
	output logic                      done,
	output logic [fps_pkg::ROOT_W-1:0] root
);
	import fps_pkg::*;

	logic        act_q;
	logic        done_q;
	logic [31:0] v_q;
	logic [31:0] r_q;
	logic [31:0] b_q;
	logic [31:0] t;

	assign t = r_q + b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				act_q <= 1'b1;
			end else if (act_q && b_q == 32'd1) begin
				act_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// one result bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			b_q <= 32'h4000_0000;
		end else if (act_q) begin
			if (v_q >= t) begin
				v_q <= v_q - t;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	// round half up: remainder above the root means the next integer
	assign done = done_q;
	assign root = ROOT_W'(r_q) + ROOT_W'(v_q > r_q);
endmodule
`default_nettype wire

/* hw/rtl/fps_div.sv */
`default_nettype none
module fps_div #(
	parameter int DW = 49,
	parameter int VW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CNW = $clog2(DW + 1);

	logic           act_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [DW-1:0]  num_q;
	logic [VW-1:0]  rem_q;
	logic [VW-1:0]  den_q;
	logic [VW:0]    rsh;
	logic           take;

	assign rsh  = {rem_q, num_q[DW-1]};
	assign take = rsh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNW'(DW - 1)) begin
					act_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (act_q) begin
			rem_q <= take ? VW'(rsh - {1'b0, den_q}) : VW'(rsh);
			num_q <= {num_q[DW-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = num_q;
endmodule
`default_nettype wire

/* hw/rtl/fps_checker.sv */
`default_nettype none
`include "frame_perceptual_scorer_core_macros.svh"
module fps_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        pix_ready,
	input wire                        res_valid,
	input wire                        res_ready,
	input wire [fps_pkg::SCORE_W-1:0] score,
	input wire [fps_pkg::SCORE_W-1:0] motion_score,
	input wire [fps_pkg::SCORE_W-1:0] edge_score,
	input wire [fps_pkg::SCORE_W-1:0] stability_score
);
	import fps_pkg::*;

	`FPS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`FPS_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(score) && $stable(motion_score) && $stable(edge_score) && $stable(stability_score), "result changed while stalled")
	`FPS_ASSERT_NOW(a_res_after_busy, $rose(res_valid), !$past(pix_ready), "result appeared while pixel input was open")
	`FPS_ASSERT_NOW(a_res_range, res_valid, score <= SCORE_W'(ONE_Q16) && motion_score <= SCORE_W'(ONE_Q16) && edge_score <= SCORE_W'(ONE_Q16) && stability_score <= SCORE_W'(ONE_Q16), "score above one")
endmodule

bind frame_perceptual_scorer_core fps_checker u_fps_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.pix_ready       (pixels.ready),
	.res_valid       (results.valid),
	.res_ready       (results.ready),
	.score           (results.score),
	.motion_score    (results.motion_score),
	.edge_score      (results.edge_score),
	.stability_score (results.stability_score)
);
`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fps_pkg::*;

	localparam int MAXW = 320;
	localparam int MAXH = 240;
	localparam int SETTLE_CYCLES = 400;
	localparam int ITEM_TARGET = 650;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [SCORE_W-1:0] total;
		logic [SCORE_W-1:0] motion;
		logic [SCORE_W-1:0] edges;
		logic [SCORE_W-1:0] stable;
	} scores_t;

	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic             fs;
		bit               typed;
		scores_t          scores;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fps_cfg_if cfg_if();
	fps_pix_if pix_if();
	fps_res_if res_if();

	frame_perceptual_scorer_core #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_if),
		.pixels  (pix_if),
		.results (res_if)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow of the scorer
	byte unsigned prev_frame[MAXW*MAXH];
	byte unsigned line_rows[3*MAXW];
	int unsigned col_pos, row_pos, changed_cnt, diff_sum, mag_sum;
	int unsigned reg_width, reg_height, reg_thr;
	int unsigned cur_w, cur_h, done_w, done_h;

	scores_t pending_scores[$];
	int errors = 0;
	int items = 0;
	bit quiet = 1'b0;

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		return v < 3 ? 3 : (v > hi ? hi : v);
	endfunction

	function automatic int unsigned int_sqrt(int unsigned v);
		int unsigned r, b;
		r = 0;
		b = 1 << 30;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int unsigned reflect(int i, int n);
		if (i < 0) i = -i;
		if (i >= n) i = 2 * n - 2 - i;
		return i;
	endfunction

	function automatic int tap(int r, int c);
		int unsigned rr, cc;
		rr = reflect(r, cur_h) % 3;
		cc = reflect(c, cur_w);
		return line_rows[(rr * MAXW + cc) % (3 * MAXW)];
	endfunction

	function automatic void add_gradient(int r, int c);
		int gx, gy;
		int unsigned n, s;
		longint unsigned acc;
		gx = (tap(r-1, c+1) + 2*tap(r, c+1) + tap(r+1, c+1))
			- (tap(r-1, c-1) + 2*tap(r, c-1) + tap(r+1, c-1));
		gy = (tap(r+1, c-1) + 2*tap(r+1, c) + tap(r+1, c+1))
			- (tap(r-1, c-1) + 2*tap(r-1, c) + tap(r-1, c+1));
		n = 256 * (gx * gx + gy * gy);
		s = int_sqrt(n);
		if (n - s * s > s) s++;
		acc = longint'(mag_sum) + s;
		mag_sum = acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : acc[31:0];
	endfunction

	function automatic bit score_frame_pixel(input int unsigned p, input bit fs,
		output scores_t res);
		int unsigned idx, prv, d;
		int r, c;
		longint unsigned n, m, e, s, t;
		res = '0;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos == 0 && row_pos == 0) begin
			cur_w = clamp_size(reg_width, MAXW);
			cur_h = clamp_size(reg_height, MAXH);
			changed_cnt = 0;
			diff_sum = 0;
			mag_sum = 0;
		end
		idx = (row_pos * cur_w + col_pos) % (MAXW * MAXH);
		prv = (cur_w == done_w && cur_h == done_h) ? prev_frame[idx] : 0;
		d = p > prv ? p - prv : prv - p;
		if (d > reg_thr) changed_cnt++;
		diff_sum += d;
		prev_frame[idx] = p;
		line_rows[((row_pos % 3) * MAXW + col_pos) % (3 * MAXW)] = p;
		r = row_pos;
		c = col_pos;
		if (r >= 1 && c >= 1) begin
			add_gradient(r - 1, c - 1);
			if (c == cur_w - 1) add_gradient(r - 1, c);
		end
		if (r == cur_h - 1 && c >= 1) begin
			add_gradient(r, c - 1);
			if (c == cur_w - 1) add_gradient(r, c);
		end
		col_pos++;
		if (col_pos >= cur_w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= cur_h) begin
				row_pos = 0;
				n = longint'(cur_w) * cur_h;
				m = (longint'(changed_cnt) * 655360 + n / 2) / n;
				if (m > ONE_Q16) m = ONE_Q16;
				e = (longint'(mag_sum) * 65536 + 400 * n) / (800 * n);
				if (e > ONE_Q16) e = ONE_Q16;
				s = (longint'(diff_sum) * 65536 + (255 * n) / 2) / (255 * n);
				s = s > ONE_Q16 ? 0 : ONE_Q16 - s;
				t = (5 * m + 3 * e + 2 * s + 5) / 10;
				if (t > ONE_Q16) t = ONE_Q16;
				res.total = t[SCORE_W-1:0];
				res.motion = m[SCORE_W-1:0];
				res.edges = e[SCORE_W-1:0];
				res.stable = s[SCORE_W-1:0];
				done_w = cur_w;
				done_h = cur_h;
				changed_cnt = 0;
				diff_sum = 0;
				mag_sum = 0;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data = val[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_FRAME_WIDTH:      reg_width = val & 32'h1FF;
			CFG_FRAME_HEIGHT:     reg_height = val & 32'hFF;
			CFG_MOTION_THRESHOLD: reg_thr = val & 32'hFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic send_pixel(input int unsigned p, input bit fs, input bit typed,
		input scores_t typed_scores);
		int gap;
		scores_t res;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			pix_if.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_if.valid = 1'b1;
		pix_if.pixel = p[PIX_W-1:0];
		pix_if.frame_start = fs;
		do @(posedge clk); while (!pix_if.ready);
		items++;
		if (score_frame_pixel(p, fs, res))
			pending_scores.push_back(typed ? typed_scores : res);
	endtask

	task automatic drain;
		@(negedge clk);
		pix_if.valid = 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int unsigned make_pixel(int mode, int unsigned base, int i);
		case (mode)
			0: return $urandom_range(0, 255);
			1: return (base + $urandom_range(0, 15)) & 8'hFF;
			default: return (i % 2 == 0) ? 255 : 0;
		endcase
	endfunction

	task automatic run_frames(int nframes);
		int unsigned n, len, base;
		int mode;
		bit fs;
		n = clamp_size(reg_width, MAXW) * clamp_size(reg_height, MAXH);
		for (int f = 0; f < nframes; f++) begin
			mode = $urandom_range(0, 3);
			base = $urandom_range(0, 255);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
			for (int i = 0; i < len; i++) begin
				fs = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 63) == 0);
				send_pixel(make_pixel(mode, base, i), fs, 1'b0, '0);
			end
		end
	endtask

	// result sink with random backpressure
	initial begin
		int k;
		res_if.ready = 1'b0;
		forever begin
			k = quiet ? 0 : $urandom_range(0, 7);
			if (k > 0) begin
				@(negedge clk);
				res_if.ready = 1'b0;
				repeat (k - 1) @(negedge clk);
			end
			@(negedge clk);
			res_if.ready = 1'b1;
			do @(posedge clk); while (!(arst_n && res_if.valid));
		end
	end

	// result checker
	initial begin
		scores_t got, want;
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready) begin
				got.total = res_if.score;
				got.motion = res_if.motion_score;
				got.edges = res_if.edge_score;
				got.stable = res_if.stability_score;
				if (pending_scores.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transaction: %0d %0d %0d %0d",
							got.total, got.motion, got.edges, got.stable);
				end else begin
					want = pending_scores.pop_front();
					if (got != want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch exp %0d %0d %0d %0d got %0d %0d %0d %0d",
								want.total, want.motion, want.edges, want.stable,
								got.total, got.motion, got.edges, got.stable);
					end
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("frame_perceptual_scorer_core test failed");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		int phase, waited;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		pix_if.valid = 1'b0;
		pix_if.pixel = '0;
		pix_if.frame_start = 1'b0;
		foreach (prev_frame[i]) prev_frame[i] = 0;
		foreach (line_rows[i]) line_rows[i] = 0;
		col_pos = 0; row_pos = 0;
		changed_cnt = 0; diff_sum = 0; mag_sum = 0;
		reg_width = FW_RST; reg_height = FH_RST; reg_thr = THR_RST;
		cur_w = FW_RST; cur_h = FH_RST; done_w = FW_RST; done_h = FH_RST;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(CFG_FRAME_WIDTH, 3);
		write_reg(CFG_FRAME_HEIGHT, 3);
		write_reg(CFG_MOTION_THRESHOLD, 30);

		// black frame after a size change, then white, then a dropped partial frame
		for (int i = 0; i < 9; i++) begin
			row = '{8'd0, i == 0, i == 8, '{17'd13107, 17'd0, 17'd0, 17'd65536}};
			rows.push_back(row);
		end
		for (int i = 0; i < 9; i++) begin
			row = '{8'd255, i == 0, i == 8, '{17'd32768, 17'd65536, 17'd0, 17'd0}};
			rows.push_back(row);
		end
		for (int i = 0; i < 4; i++) begin
			row = '{(i % 2) ? 8'd0 : 8'd255, i == 0, 1'b0, '0};
			rows.push_back(row);
		end
		foreach (rows[i]) send_pixel(rows[i].pixel, rows[i].fs, rows[i].typed, rows[i].scores);
		drain();

		phase = 0;
		while (items < ITEM_TARGET + 22) begin
			quiet = ($urandom_range(0, 3) == 0);
			write_reg(CFG_SPARE, $urandom_range(0, 511));
			if (phase == 2) begin
				write_reg(CFG_FRAME_WIDTH, 0);
				write_reg(CFG_FRAME_HEIGHT, 0);
				write_reg(CFG_MOTION_THRESHOLD, 0);
				run_frames(1);
			end else if (phase == 5) begin
				write_reg(CFG_FRAME_HEIGHT, 1);
				write_reg(CFG_FRAME_WIDTH, 2);
				write_reg(CFG_MOTION_THRESHOLD, 255);
				run_frames(1);
			end else begin
				write_reg(CFG_MOTION_THRESHOLD,
					($urandom_range(0, 4) == 0) ? 255 * $urandom_range(0, 1)
					: $urandom_range(0, 255));
				if ($urandom_range(0, 2) != 0) begin
					write_reg(CFG_FRAME_WIDTH, $urandom_range(3, 6));
					write_reg(CFG_FRAME_HEIGHT, $urandom_range(3, 5));
				end
				run_frames($urandom_range(1, 4));
			end
			drain();
			phase++;
		end

		waited = 0;
		while (pending_scores.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_scores.size() != 0) errors++;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("frame_perceptual_scorer_core test passed");
		else
			$display("frame_perceptual_scorer_core test failed");
		$finish;
	end

endmodule
`default_nettype wire

/* frame_perceptual_scorer_core.f */
+incdir+hw/rtl
hw/rtl/fps_pkg.sv
hw/rtl/fps_if.sv
hw/rtl/fps_ram.sv
hw/rtl/fps_sqrt.sv
hw/rtl/fps_div.sv
hw/rtl/frame_perceptual_scorer_core.sv
hw/rtl/fps_checker.sv
sim/tb_top.sv
